// File: design/ctsr_pkg.sv
// Shared constants, codes and controller/datapath interface types.
`timescale 1ns / 1ps
package ctsr_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int METRIC_BITS = 21;

  // datapath operations, one per sequencer step
  localparam logic [3:0] OP_VEL  = 4'd0;  // velocity divide, lane idx
  localparam logic [3:0] OP_GP   = 4'd1;  // gamma * p
  localparam logic [3:0] OP_C2   = 4'd2;  // (gamma * p) / rho
  localparam logic [3:0] OP_SQC  = 4'd3;  // sound speed root
  localparam logic [3:0] OP_DOT  = 4'd4;  // metric * velocity accumulate
  localparam logic [3:0] OP_SQ   = 4'd5;  // metric squared accumulate
  localparam logic [3:0] OP_SQN  = 4'd6;  // metric norm root
  localparam logic [3:0] OP_CN   = 4'd7;  // c * n, direction sum
  localparam logic [3:0] OP_RATE = 4'd8;  // sum / jacobian, running max
  localparam logic [3:0] OP_STEP = 4'd9;  // Courant target / max, result

  // configuration register indexes
  localparam logic [2:0] REG_HEAT_RATIO    = 3'd0;
  localparam logic [2:0] REG_BASE_DENSITY  = 3'd1;
  localparam logic [2:0] REG_BASE_PRESSURE = 3'd2;
  localparam logic [2:0] REG_CFL_TARGET    = 3'd3;
  localparam logic [2:0] REG_FALLBACK_STEP = 3'd4;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] dir;
    logic [1:0] idx;
    logic       load;
    logic       start;
    logic       wb;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic last;
    logic out_block;
  } status_t;

endpackage

// File: design/cfl_time_step_reduction_core.sv
// Top level: CFL time-step reduction, sequencer plus shared-unit datapath.
//
//  channel  direction  handshake            payload
//  in       input      in_valid/in_ready    rho_pert..last_cell, one cell
//  out      output     out_valid/out_ready  time_step, max_rate, flags
//  cfg      input      cfg_we               cfg_index, cfg_data
//
// A cell runs five divides (three velocities, c2, rate), four roots and 22
// multiply steps, each through the issue, wait and writeback states, after the
// accept. A last cell adds the step divide, not started when the max is zero.
// Reset is synchronous; no clearing pass. The next cell is taken once the
// current one finishes; a result waiting in the output register stalls only
// the final step of the next last cell.
`timescale 1ns / 1ps
module cfl_time_step_reduction_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [30:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  rho_pert,
  input  logic signed [31:0]  mom_x,
  input  logic signed [31:0]  mom_y,
  input  logic signed [31:0]  mom_z,
  input  logic signed [31:0]  p_pert,
  input  logic [62:0]         xi_metrics,
  input  logic [62:0]         eta_metrics,
  input  logic [62:0]         zeta_metrics,
  input  logic [30:0]         jacobian,
  input  logic                last_cell,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [30:0]         time_step,
  output logic [31:0]         max_rate,
  output logic                used_fallback,
  output logic                saturated
);

  ctsr_pkg::cmd_t    cmd;
  ctsr_pkg::status_t status;

  // controller: one transaction in flight, steps the operation list
  ctsr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  // datapath: config, operands, shared units, running max, result register
  ctsr_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .rho_pert      (rho_pert),
    .mom_x         (mom_x),
    .mom_y         (mom_y),
    .mom_z         (mom_z),
    .p_pert        (p_pert),
    .xi_metrics    (xi_metrics),
    .eta_metrics   (eta_metrics),
    .zeta_metrics  (zeta_metrics),
    .jacobian      (jacobian),
    .last_cell     (last_cell),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .time_step     (time_step),
    .max_rate      (max_rate),
    .used_fallback (used_fallback),
    .saturated     (saturated)
  );

endmodule

// File: design/ctsr_div.sv
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit a cycle.
`timescale 1ns / 1ps
module ctsr_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic        busy,
  output logic [63:0] quo
);

  logic [31:0] rem;
  logic [31:0] dvs;
  logic [5:0]  count;
  logic [32:0] trial;
  logic        fits;

  assign trial = {rem, quo[63]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= 6'd63;
    end else if (busy) begin
      count <= count - 6'd1;
      if (count == 6'd0) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
      dvs <= den;
    end else if (busy) begin
      rem <= fits ? 32'(trial - {1'b0, dvs}) : trial[31:0];
      quo <= {quo[62:0], fits};
    end
  end

endmodule

// File: design/ctsr_sqrt.sv
// Floor square root of a 64-bit value, two radicand bits a cycle.
`timescale 1ns / 1ps
module ctsr_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] rad_in,
  output logic        busy,
  output logic [31:0] root
);

  logic [63:0] rad;
  logic [33:0] rem;
  logic [4:0]  count;
  logic [35:0] shifted;
  logic [35:0] trial;
  logic        fits;

  assign shifted = {rem, rad[63:62]};
  assign trial   = {2'b00, root, 2'b01};
  assign fits    = shifted >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= 5'd31;
    end else if (busy) begin
      count <= count - 5'd1;
      if (count == 5'd0) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= rad_in;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[61:0], 2'b00};
      rem  <= fits ? 34'(shifted - trial) : shifted[33:0];
      root <= {root[30:0], fits};
    end
  end

endmodule

// File: design/ctsr_datapath.sv
// Datapath: operand registers, shared multiplier, divider and root units, result.
`timescale 1ns / 1ps
module ctsr_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  ctsr_pkg::cmd_t       cmd,
  output ctsr_pkg::status_t    status,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [30:0]          cfg_data,
  input  logic signed [31:0]   rho_pert,
  input  logic signed [31:0]   mom_x,
  input  logic signed [31:0]   mom_y,
  input  logic signed [31:0]   mom_z,
  input  logic signed [31:0]   p_pert,
  input  logic [62:0]          xi_metrics,
  input  logic [62:0]          eta_metrics,
  input  logic [62:0]          zeta_metrics,
  input  logic [30:0]          jacobian,
  input  logic                 last_cell,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [30:0]          time_step,
  output logic [31:0]          max_rate,
  output logic                 used_fallback,
  output logic                 saturated
);

  localparam int F  = ctsr_pkg::FRAC_BITS;
  localparam int MB = ctsr_pkg::METRIC_BITS;

  // config
  logic [18:0] heat_ratio;
  logic [30:0] base_density, base_pressure, courant, fallback_step;

  // cell operands
  logic signed [31:0] mom [3];
  logic [62:0]        met [3];
  logic [30:0]        jac;
  logic               last;
  logic [30:0]        rho, p;

  // intermediates
  logic signed [31:0] vel [3];
  logic [31:0]        c2;
  logic [23:0]        c;
  logic signed [53:0] dot;
  logic [41:0]        nsq;
  logic [20:0]        n;
  logic [39:0]        sum;
  logic [31:0]        running_max;
  logic               sat_sticky;
  logic signed [63:0] mul_p;

  // shared units
  logic        div_busy, sqrt_busy;
  logic [63:0] div_quo;
  logic [31:0] sqrt_root;
  logic        div_start, sqrt_start;
  logic [63:0] div_num, sqrt_rad;
  logic [31:0] div_den;

  logic signed [31:0] mul_a, mul_b;
  logic signed [31:0] mom_sel;
  logic [31:0]        mag;
  logic [62:0]        met_sel;
  logic [MB-1:0]      m_field;
  logic signed [31:0] m32;
  logic [31:0]        rho_fl, p_fl;
  logic [37:0]        u_mag;

  function automatic logic [31:0] floor_tot(logic [30:0] base, logic [31:0] pert);
    logic signed [32:0] t;
    logic [31:0]        r;
    t = $signed({2'b00, base}) + $signed({pert[31], pert});
    if (t < 33'sd1) r = 32'd1;
    else if (t > 33'sh07FFF_FFFF) r = {1'b1, 31'h7FFF_FFFF};
    else r = {1'b0, t[30:0]};
    return r;
  endfunction

  assign rho_fl  = floor_tot(base_density, rho_pert);
  assign p_fl    = floor_tot(base_pressure, p_pert);
  assign mom_sel = mom[cmd.idx];
  assign mag     = mom_sel[31] ? 32'(32'd0 - mom_sel) : mom_sel;
  assign met_sel = met[cmd.dir];
  assign m_field = met_sel[cmd.idx * MB +: MB];
  assign m32     = 32'($signed(m_field));
  assign u_mag   = dot[53] ? 38'((-dot) >>> F) : 38'(dot >>> F);

  // operand selection
  always_comb begin
    mul_a      = '0;
    mul_b      = '0;
    div_num    = '0;
    div_den    = 32'd1;
    sqrt_rad   = '0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    case (cmd.op)
      ctsr_pkg::OP_VEL: begin
        div_num   = 64'(mag) << F;
        div_den   = (base_density != '0) ? {1'b0, base_density} : 32'd1;
        div_start = cmd.start;
      end
      ctsr_pkg::OP_GP: begin
        mul_a = $signed({13'b0, heat_ratio});
        mul_b = $signed({1'b0, p});
      end
      ctsr_pkg::OP_C2: begin
        div_num   = mul_p;
        div_den   = {1'b0, rho};
        div_start = cmd.start;
      end
      ctsr_pkg::OP_SQC: begin
        sqrt_rad   = 64'(c2) << F;
        sqrt_start = cmd.start;
      end
      ctsr_pkg::OP_DOT: begin
        mul_a = m32;
        mul_b = vel[cmd.idx];
      end
      ctsr_pkg::OP_SQ: begin
        mul_a = m32;
        mul_b = m32;
      end
      ctsr_pkg::OP_SQN: begin
        sqrt_rad   = 64'(nsq);
        sqrt_start = cmd.start;
      end
      ctsr_pkg::OP_CN: begin
        mul_a = $signed({8'b0, c});
        mul_b = $signed({11'b0, n});
      end
      ctsr_pkg::OP_RATE: begin
        div_num   = 64'(sum) << F;
        div_den   = (jac != '0) ? {1'b0, jac} : 32'd1;
        div_start = cmd.start;
      end
      ctsr_pkg::OP_STEP: begin
        div_num   = 64'(courant) << F;
        div_den   = running_max;
        div_start = cmd.start && (running_max != '0);
      end
      default: ;
    endcase
  end

  ctsr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  ctsr_sqrt u_sqrt (
    .clk    (clk),
    .rst    (rst),
    .start  (sqrt_start),
    .rad_in (sqrt_rad),
    .busy   (sqrt_busy),
    .root   (sqrt_root)
  );

  assign status.busy      = div_busy | sqrt_busy;
  assign status.last      = last;
  assign status.out_block = out_valid & ~out_ready;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      heat_ratio    <= 19'd91750;
      base_density  <= 31'd65536;
      base_pressure <= 31'd65536;
      courant       <= 31'd32768;
      fallback_step <= 31'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ctsr_pkg::REG_HEAT_RATIO:    heat_ratio    <= cfg_data[18:0];
        ctsr_pkg::REG_BASE_DENSITY:  base_density  <= cfg_data;
        ctsr_pkg::REG_BASE_PRESSURE: base_pressure <= cfg_data;
        ctsr_pkg::REG_CFL_TARGET:    courant       <= cfg_data;
        ctsr_pkg::REG_FALLBACK_STEP: fallback_step <= cfg_data;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mom[0] <= mom_x;
      mom[1] <= mom_y;
      mom[2] <= mom_z;
      met[0] <= xi_metrics;
      met[1] <= eta_metrics;
      met[2] <= zeta_metrics;
      jac    <= jacobian;
      last   <= last_cell;
      rho    <= rho_fl[30:0];
      p      <= p_fl[30:0];
    end
    if (cmd.start) mul_p <= mul_a * mul_b;
    if (cmd.wb) begin
      case (cmd.op)
        ctsr_pkg::OP_VEL: begin
          if (mom_sel[31]) begin
            vel[cmd.idx] <= (div_quo > 64'h8000_0000) ? 32'sh8000_0000
                                                      : -$signed(div_quo[31:0]);
          end else begin
            vel[cmd.idx] <= (div_quo > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                      : $signed(div_quo[31:0]);
          end
        end
        ctsr_pkg::OP_C2:
          c2 <= (div_quo[63:32] != '0) ? 32'hFFFF_FFFF : div_quo[31:0];
        ctsr_pkg::OP_SQC: c <= sqrt_root[23:0];
        ctsr_pkg::OP_DOT:
          dot <= (cmd.idx == 2'd0) ? mul_p[53:0] : dot + mul_p[53:0];
        ctsr_pkg::OP_SQ:
          nsq <= (cmd.idx == 2'd0) ? mul_p[41:0] : nsq + mul_p[41:0];
        ctsr_pkg::OP_SQN: n <= sqrt_root[20:0];
        ctsr_pkg::OP_CN:
          sum <= ((cmd.dir == 2'd0) ? 40'd0 : sum) + 40'(u_mag)
                 + 40'(mul_p[44:F]);
        default: ;
      endcase
    end
  end

  // running max, sticky flag and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      running_max <= '0;
      sat_sticky  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.load && (rho_fl[31] || p_fl[31])) sat_sticky <= 1'b1;
      if (cmd.wb) begin
        case (cmd.op)
          ctsr_pkg::OP_VEL: begin
            if (mom_sel[31] ? (div_quo > 64'h8000_0000) : (div_quo > 64'h7FFF_FFFF))
              sat_sticky <= 1'b1;
          end
          ctsr_pkg::OP_C2, ctsr_pkg::OP_RATE: begin
            if (div_quo[63:32] != '0) sat_sticky <= 1'b1;
            if (cmd.op == ctsr_pkg::OP_RATE) begin
              if (div_quo[63:32] != '0) running_max <= 32'hFFFF_FFFF;
              else if (div_quo[31:0] > running_max) running_max <= div_quo[31:0];
            end
          end
          ctsr_pkg::OP_STEP: begin
            out_valid     <= 1'b1;
            max_rate      <= running_max;
            running_max   <= '0;
            sat_sticky    <= 1'b0;
            if (running_max == '0) begin
              time_step     <= (fallback_step != '0) ? fallback_step : 31'd1;
              used_fallback <= 1'b1;
              saturated     <= sat_sticky;
            end else begin
              used_fallback <= 1'b0;
              if (div_quo[63:31] != '0) begin
                time_step <= 31'h7FFF_FFFF;
                saturated <= 1'b1;
              end else begin
                time_step <= (div_quo[30:0] == '0) ? 31'd1 : div_quo[30:0];
                saturated <= sat_sticky;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> !(div_busy || sqrt_busy))
    else $error("unit started while busy");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.wb && cmd.op == ctsr_pkg::OP_STEP) |-> !(out_valid && !out_ready))
    else $error("result register overwritten");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !(div_busy || sqrt_busy) && !cmd.wb)
    else $error("cell loaded during work");

endmodule

// File: design/ctsr_ctrl.sv
// Sequencer: steps the datapath through the per-cell operation list.
`timescale 1ns / 1ps
module ctsr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output ctsr_pkg::cmd_t    cmd,
  input  ctsr_pkg::status_t status
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_WB    = 2'd3;

  logic [1:0] state, state_next;
  logic [3:0] op, op_next;
  logic [1:0] dir, dir_next;
  logic [1:0] idx, idx_next;
  logic       done;

  assign in_ready = (state == S_IDLE);

  // next operation in the list
  always_comb begin
    op_next  = op;
    dir_next = dir;
    idx_next = idx;
    done     = 1'b0;
    unique case (op)
      ctsr_pkg::OP_VEL: begin
        if (idx == 2'd2) begin
          op_next  = ctsr_pkg::OP_GP;
          idx_next = 2'd0;
        end else idx_next = idx + 2'd1;
      end
      ctsr_pkg::OP_GP:  op_next = ctsr_pkg::OP_C2;
      ctsr_pkg::OP_C2:  op_next = ctsr_pkg::OP_SQC;
      ctsr_pkg::OP_SQC: begin
        op_next  = ctsr_pkg::OP_DOT;
        dir_next = 2'd0;
        idx_next = 2'd0;
      end
      ctsr_pkg::OP_DOT: begin
        if (idx == 2'd2) begin
          op_next  = ctsr_pkg::OP_SQ;
          idx_next = 2'd0;
        end else idx_next = idx + 2'd1;
      end
      ctsr_pkg::OP_SQ: begin
        if (idx == 2'd2) op_next = ctsr_pkg::OP_SQN;
        else idx_next = idx + 2'd1;
      end
      ctsr_pkg::OP_SQN: op_next = ctsr_pkg::OP_CN;
      ctsr_pkg::OP_CN: begin
        idx_next = 2'd0;
        if (dir == 2'd2) op_next = ctsr_pkg::OP_RATE;
        else begin
          op_next  = ctsr_pkg::OP_DOT;
          dir_next = dir + 2'd1;
        end
      end
      ctsr_pkg::OP_RATE: begin
        if (status.last) op_next = ctsr_pkg::OP_STEP;
        else done = 1'b1;
      end
      default: done = 1'b1;
    endcase
  end

  always_comb begin
    state_next = state;
    cmd.op     = op;
    cmd.dir    = dir;
    cmd.idx    = idx;
    cmd.load   = 1'b0;
    cmd.start  = 1'b0;
    cmd.wb     = 1'b0;
    unique case (state)
      S_IDLE: if (in_valid) begin
        cmd.load   = 1'b1;
        state_next = S_ISSUE;
      end
      S_ISSUE: begin
        cmd.start  = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: if (!status.busy) state_next = S_WB;
      S_WB: begin
        if (!(op == ctsr_pkg::OP_STEP && status.out_block)) begin
          cmd.wb     = 1'b1;
          state_next = done ? S_IDLE : S_ISSUE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= ctsr_pkg::OP_VEL;
      dir   <= '0;
      idx   <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE) begin
        op  <= ctsr_pkg::OP_VEL;
        dir <= '0;
        idx <= '0;
      end else if (cmd.wb) begin
        op  <= op_next;
        dir <= dir_next;
        idx <= idx_next;
      end
    end
  end

endmodule

// File: verif/cfl_time_step_reduction_core_test.sv
// Self-checking testbench for the CFL time-step reduction core.
`timescale 1ns / 1ps
module cfl_time_step_reduction_core_test;

  // index past the last register, must be ignored by the block
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 232;
  localparam int QUIET_ITEMS = 200;    // tail of the run without idling
  localparam int LONG_HOLD = 4000;     // receiver hold-off, cycles
  localparam int SETTLE = 700;         // more than one cell plus the final divide
  localparam longint unsigned M31 = 64'h7FFF_FFFF;
  localparam longint unsigned M32 = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] rho_pert;
    logic [31:0] mom_x;
    logic [31:0] mom_y;
    logic [31:0] mom_z;
    logic [31:0] p_pert;
    logic [62:0] xi;
    logic [62:0] eta;
    logic [62:0] zeta;
    logic [30:0] jac;
    logic        last;
  } cell_t;

  typedef struct packed {
    logic [30:0] step;
    logic [31:0] max_rate;
    logic        fallback;
    logic        sat;
  } step_result_t;

  // one row of the directed table; typed marks a hand-written expectation
  typedef struct packed {
    cell_t        stim;
    logic         typed;
    step_result_t res;
  } dir_row_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = ctsr_pkg::REG_HEAT_RATIO;
  logic [30:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] rho_pert = '0, mom_x = '0, mom_y = '0, mom_z = '0, p_pert = '0;
  logic [62:0] xi_metrics = '0, eta_metrics = '0, zeta_metrics = '0;
  logic [30:0] jacobian = 31'd1;
  logic last_cell = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [30:0] time_step;
  logic [31:0] max_rate;
  logic used_fallback;
  logic saturated;

  cfl_time_step_reduction_core i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .rho_pert(rho_pert), .mom_x(mom_x), .mom_y(mom_y), .mom_z(mom_z), .p_pert(p_pert),
    .xi_metrics(xi_metrics), .eta_metrics(eta_metrics), .zeta_metrics(zeta_metrics),
    .jacobian(jacobian), .last_cell(last_cell),
    .out_valid(out_valid), .out_ready(out_ready),
    .time_step(time_step), .max_rate(max_rate),
    .used_fallback(used_fallback), .saturated(saturated)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------
  // Predictor: own copy of the registers and the block state
  // ---------------------------------------------------------------------
  longint unsigned gamma_q, rho0_q, p0_q, cfl_q, fallback_q;
  longint unsigned peak_rate;
  bit sat_flag;
  step_result_t step_results_q[$];

  int mismatches = 0;
  bit quiet = 1'b0;      // no idling on either side
  bit hold_req = 1'b0;   // ask the receiver for a long hold-off

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint velocity_of(logic signed [31:0] m, longint unsigned rho0);
    longint sm;
    longint unsigned mag, q;
    sm = longint'(m);
    mag = (sm < 0) ? longint'(-sm) : sm;
    q = (mag << ctsr_pkg::FRAC_BITS) / rho0;
    if (sm < 0) begin
      if (q > 64'h8000_0000) begin
        sat_flag = 1'b1;
        q = 64'h8000_0000;
      end
      return -longint'(q);
    end
    if (q > M31) begin
      sat_flag = 1'b1;
      q = M31;
    end
    return longint'(q);
  endfunction

  // floored, saturated total of background plus perturbation
  function automatic longint total_of(longint unsigned base, logic signed [31:0] pert);
    longint t;
    t = longint'(base) + longint'(pert);
    if (t < 1) t = 1;
    if (t > longint'(M31)) begin
      sat_flag = 1'b1;
      t = longint'(M31);
    end
    return t;
  endfunction

  function automatic longint unsigned dir_speed(logic [62:0] pk, longint v0, longint v1,
                                                longint v2, longint unsigned c);
    logic signed [ctsr_pkg::METRIC_BITS-1:0] f;
    longint m, dot;
    longint unsigned nsq, u;
    dot = 0;
    nsq = 0;
    for (int i = 0; i < 3; i++) begin
      f = pk[i*ctsr_pkg::METRIC_BITS +: ctsr_pkg::METRIC_BITS];
      m = longint'(f);
      dot += m * ((i == 0) ? v0 : (i == 1) ? v1 : v2);
      nsq += m * m;
    end
    u = ((dot < 0) ? -dot : dot) >> ctsr_pkg::FRAC_BITS;
    return u + ((c * root_floor(nsq)) >> ctsr_pkg::FRAC_BITS);
  endfunction

  // Runs one accepted cell; returns 1 and the step result on a last cell.
  function automatic bit predict_step(cell_t cl, output step_result_t r);
    longint unsigned rho0, c2, c, sum, jac, rate, st;
    longint v0, v1, v2, rho, p;
    rho0 = (rho0_q != 0) ? rho0_q : 1;
    v0 = velocity_of(cl.mom_x, rho0);
    v1 = velocity_of(cl.mom_y, rho0);
    v2 = velocity_of(cl.mom_z, rho0);
    rho = total_of(rho0_q, cl.rho_pert);
    p = total_of(p0_q, cl.p_pert);
    c2 = (gamma_q * longint'(p)) / longint'(rho);
    if (c2 > M32) begin
      sat_flag = 1'b1;
      c2 = M32;
    end
    c = root_floor(c2 << ctsr_pkg::FRAC_BITS);
    sum = dir_speed(cl.xi, v0, v1, v2, c) + dir_speed(cl.eta, v0, v1, v2, c)
        + dir_speed(cl.zeta, v0, v1, v2, c);
    jac = (cl.jac != 0) ? cl.jac : 1;
    if (sum > (64'hFFFF_FFFF_FFFF_FFFF >> ctsr_pkg::FRAC_BITS)) begin
      rate = M32;
      sat_flag = 1'b1;
    end else begin
      rate = (sum << ctsr_pkg::FRAC_BITS) / jac;
      if (rate > M32) begin
        sat_flag = 1'b1;
        rate = M32;
      end
    end
    if (rate > peak_rate) peak_rate = rate;
    r = '0;
    if (!cl.last) return 1'b0;
    if (peak_rate == 0) begin
      st = (fallback_q != 0) ? fallback_q : 1;
      r.fallback = 1'b1;
    end else begin
      st = (cfl_q << ctsr_pkg::FRAC_BITS) / peak_rate;
      if (st > M31) begin
        sat_flag = 1'b1;
        st = M31;
      end
      if (st == 0) st = 1;
    end
    r.step = st[30:0];
    r.max_rate = peak_rate[31:0];
    r.sat = sat_flag;
    peak_rate = 0;
    sat_flag = 1'b0;
    return 1'b1;
  endfunction

  function automatic void pred_reset();
    gamma_q = 91750;
    rho0_q = 65536;
    p0_q = 65536;
    cfl_q = 32768;
    fallback_q = 1;
    peak_rate = 0;
    sat_flag = 1'b0;
  endfunction

  // ---------------------------------------------------------------------
  // Configuration writes, only while the block is idle; caller drops cfg_we
  // ---------------------------------------------------------------------
  task automatic write_reg(logic [2:0] idx, logic [30:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      ctsr_pkg::REG_HEAT_RATIO:    gamma_q = val[18:0];
      ctsr_pkg::REG_BASE_DENSITY:  rho0_q = val;
      ctsr_pkg::REG_BASE_PRESSURE: p0_q = val;
      ctsr_pkg::REG_CFL_TARGET:    cfl_q = val;
      ctsr_pkg::REG_FALLBACK_STEP: fallback_q = val;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (step_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Sender: one transaction per cell, random gaps between them
  // ---------------------------------------------------------------------
  task automatic send_cell(cell_t cl);
    step_result_t r;
    in_valid <= 1'b1;
    rho_pert <= cl.rho_pert;
    mom_x <= cl.mom_x;
    mom_y <= cl.mom_y;
    mom_z <= cl.mom_z;
    p_pert <= cl.p_pert;
    xi_metrics <= cl.xi;
    eta_metrics <= cl.eta;
    zeta_metrics <= cl.zeta;
    jacobian <= cl.jac;
    last_cell <= cl.last;
    do @(posedge clk); while (!in_ready);
    if (predict_step(cl, r)) step_results_q.push_back(r);
    // keep valid up for back-to-back cells, otherwise idle a burst
    if (!quiet && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic send_typed(cell_t cl, step_result_t exp_r);
    int n;
    n = step_results_q.size();
    send_cell(cl);
    // replace the predicted entry with the hand-written one
    if (step_results_q.size() > n) begin
      void'(step_results_q.pop_back());
      step_results_q.push_back(exp_r);
    end
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3, 4: return ($urandom_range(0, 1) ? $urandom_range(0, 32'h3_0000)
                                         : -$urandom_range(0, 32'h3_0000));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [62:0] rand_metrics();
    logic [62:0] pk;
    logic [20:0] f;
    if ($urandom_range(0, 5) == 0) return 63'({$urandom, $urandom});
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(0, 5))
        0: f = 21'h0F_FFFF;
        1: f = 21'h10_0000;
        2: f = 21'h0;
        default: f = $urandom_range(0, 1) ? 21'($urandom_range(0, 21'h2_0000))
                                          : 21'(-$urandom_range(0, 21'h2_0000));
      endcase
      pk[i*ctsr_pkg::METRIC_BITS +: ctsr_pkg::METRIC_BITS] = f;
    end
    return pk;
  endfunction

  function automatic cell_t rand_cell(int last_odds);
    cell_t cl;
    cl.rho_pert = rand_word();
    cl.mom_x = rand_word();
    cl.mom_y = rand_word();
    cl.mom_z = rand_word();
    cl.p_pert = rand_word();
    cl.xi = rand_metrics();
    cl.eta = rand_metrics();
    cl.zeta = rand_metrics();
    case ($urandom_range(0, 9))
      0: cl.jac = 31'd0;
      1: cl.jac = 31'h7FFF_FFFF;
      2: cl.jac = 31'd1;
      3, 4: cl.jac = 31'($urandom_range(1, 31'h4_0000));
      default: cl.jac = 31'($urandom);
    endcase
    // an all-zero cell now and then, to hit a zero maximum
    if ($urandom_range(0, 30) == 0) begin
      cl = '0;
      cl.jac = 31'd1;
    end
    cl.last = ($urandom_range(1, last_odds) == 1);
    return cl;
  endfunction

  // ---------------------------------------------------------------------
  // Receiver: random stall bursts, one long hold-off on request
  // ---------------------------------------------------------------------
  initial begin
    int stall, hold;
    stall = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold = LONG_HOLD;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (quiet) begin
        out_ready <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 19) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result check: each transaction against the oldest expectation
  // ---------------------------------------------------------------------
  task automatic report(string fld, longint unsigned e, longint unsigned a);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0d, got %0d", fld, e, a);
  endtask

  always @(posedge clk) begin
    step_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (step_results_q.size() == 0) begin
        report("unexpected result", 0, 1);
      end else begin
        e = step_results_q.pop_front();
        if (time_step !== e.step) report("time_step", e.step, time_step);
        if (max_rate !== e.max_rate) report("max_rate", e.max_rate, max_rate);
        if (used_fallback !== e.fallback) report("used_fallback", e.fallback, used_fallback);
        if (saturated !== e.sat) report("saturated", e.sat, saturated);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    cell_t cl;
    step_result_t fb_rst;
    int total;
    pred_reset();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, reset register values
    fb_rst = '{step: 31'd1, max_rate: 32'd0, fallback: 1'b1, sat: 1'b0};
    row = '0;
    row.stim.jac = 31'd1;
    row.stim.last = 1'b1;
    row.typed = 1'b1;
    row.res = fb_rst;
    rows.push_back(row);                      // all-zero cell: fallback step
    row.stim.jac = 31'd0;
    rows.push_back(row);                      // zero jacobian, still no rate
    row = '0;
    row.stim = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 {3{21'h0F_FFFF}}, {3{21'h0F_FFFF}}, {3{21'h0F_FFFF}}, 31'h7FFF_FFFF, 1'b0};
    rows.push_back(row);                      // positive extremes, density and pressure saturate
    row.stim = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 {3{21'h10_0000}}, {3{21'h10_0000}}, {3{21'h10_0000}}, 31'd1, 1'b1};
    rows.push_back(row);                      // negative extremes, floors, huge rate
    row.stim = '{32'h0, 32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h0,
                 {21'h0, 21'h0, 21'h1_0000}, {21'h0, 21'h1_0000, 21'h0},
                 {21'h1_0000, 21'h0, 21'h0}, 31'h1_0000, 1'b1};
    rows.push_back(row);                      // unit metrics, ordinary cell
    row.stim = '{32'hFFFF_FFFF, 32'h1, 32'h1, 32'h1, 32'h0,
                 {3{21'h1F_FFFF}}, 63'h0, 63'h0, 31'h7FFF_FFFF, 1'b1};
    rows.push_back(row);                      // tiny rate rounds to zero, fallback step
    row.stim = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                 63'h7FFF_FFFF_FFFF_FFFF, 63'h0, 63'h0, 31'd0, 1'b0};
    rows.push_back(row);                      // all metric bits set, zero jacobian
    row.stim.last = 1'b1;
    row.stim.xi = 63'h0;
    row.stim.jac = 31'd1;
    rows.push_back(row);                      // last cell after a nonzero one
    foreach (rows[i]) begin
      if (rows[i].typed) send_typed(rows[i].stim, rows[i].res);
      else send_cell(rows[i].stim);
    end
    in_valid <= 1'b0;
    wait_drained();

    total = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        1: begin                              // low gamma and bases, top targets, bad index
          write_reg(ctsr_pkg::REG_HEAT_RATIO, 31'd65536);
          write_reg(ctsr_pkg::REG_BASE_DENSITY, 31'd1);
          write_reg(ctsr_pkg::REG_BASE_PRESSURE, 31'd1);
          write_reg(ctsr_pkg::REG_CFL_TARGET, 31'h7FFF_FFFF);
          write_reg(ctsr_pkg::REG_FALLBACK_STEP, 31'h7FFF_FFFF);
          write_reg(REG_UNUSED, 31'h7FFF_FFFF);
        end
        2: begin                              // high gamma and bases, lowest targets
          write_reg(ctsr_pkg::REG_HEAT_RATIO, 31'd262144);
          write_reg(ctsr_pkg::REG_BASE_DENSITY, 31'h7FFF_FFFF);
          write_reg(ctsr_pkg::REG_BASE_PRESSURE, 31'h7FFF_FFFF);
          write_reg(ctsr_pkg::REG_CFL_TARGET, 31'd1);
          write_reg(ctsr_pkg::REG_FALLBACK_STEP, 31'd1);
        end
        3: begin                              // zero density and zero fallback
          write_reg(ctsr_pkg::REG_HEAT_RATIO, 31'h7FFF_FFFF);
          write_reg(ctsr_pkg::REG_BASE_DENSITY, 31'd0);
          write_reg(ctsr_pkg::REG_BASE_PRESSURE, 31'($urandom_range(1, 31'h7FFF_FFFF)));
          write_reg(ctsr_pkg::REG_CFL_TARGET, 31'($urandom_range(1, 31'h7FFF_FFFF)));
          write_reg(ctsr_pkg::REG_FALLBACK_STEP, 31'd0);
        end
        4: begin
          write_reg(ctsr_pkg::REG_HEAT_RATIO, 31'($urandom_range(65536, 262144)));
          write_reg(ctsr_pkg::REG_BASE_DENSITY, 31'($urandom_range(1, 31'h7FFF_FFFF)));
          write_reg(ctsr_pkg::REG_BASE_PRESSURE, 31'($urandom_range(1, 31'h0010_0000)));
          write_reg(ctsr_pkg::REG_CFL_TARGET, 31'($urandom_range(1, 31'h0004_0000)));
          write_reg(ctsr_pkg::REG_FALLBACK_STEP, 31'($urandom_range(1, 31'h7FFF_FFFF)));
        end
        5: begin                              // back to the reset values
          write_reg(ctsr_pkg::REG_HEAT_RATIO, 31'd91750);
          write_reg(ctsr_pkg::REG_BASE_DENSITY, 31'd65536);
          write_reg(ctsr_pkg::REG_BASE_PRESSURE, 31'd65536);
          write_reg(ctsr_pkg::REG_CFL_TARGET, 31'd32768);
          write_reg(ctsr_pkg::REG_FALLBACK_STEP, 31'd1);
        end
        default: ;
      endcase
      cfg_we <= 1'b0;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // back-pressure: receiver stops while dense last cells keep coming
        if (ph == 3 && k == 20) hold_req = 1'b1;
        // sender pause until everything owed has come back
        if (ph == 4 && k == 100) begin
          in_valid <= 1'b0;
          do @(posedge clk); while (step_results_q.size() != 0);
        end
        if (total >= PHASES * PHASE_ITEMS - QUIET_ITEMS) quiet = 1'b1;
        cl = rand_cell((ph == 3 && k >= 20 && k < 40) ? 2 : 8);
        if (k == PHASE_ITEMS - 1) cl.last = 1'b1;  // leave the block empty
        send_cell(cl);
        total++;
      end
      in_valid <= 1'b0;
      wait_drained();
    end

    if (step_results_q.size() != 0) report("missing results", 0, step_results_q.size());
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog, several times the slowest expected run
  initial begin
    #100_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: sim.f
design/ctsr_pkg.sv
design/ctsr_div.sv
design/ctsr_sqrt.sv
design/ctsr_datapath.sv
design/ctsr_ctrl.sv
design/cfl_time_step_reduction_core.sv
verif/cfl_time_step_reduction_core_test.sv
